FILE: rtl/ftwa_pkg.sv
// Package: widths, codes, state encoding and control structs of the flow table.
`timescale 1ns / 1ps
package ftwa_pkg;

  localparam int unsigned EntriesDef = 1024;
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned TIME_W     = 64;
  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned BUDGET_W   = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam logic [BUDGET_W-1:0] BUDGET_RST = BUDGET_W'(64);

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_GET    = 2'd1,
    KIND_DEL    = 2'd2,
    KIND_AGE    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IDLE_TIMEOUT = 2'd0,
    CFG_SCAN_BUDGET  = 2'd1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SRCH,
    S_FLRD,
    S_CREATE,
    S_DROP,
    S_AREAD,
    S_ACHK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key_hi;
    logic [KEY_W-1:0]   key_lo;
    logic [TIME_W-1:0]  birth;
    logic [TIME_W-1:0]  touched;
  } entry_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic srch;
    logic miss;
    logic full;
    logic create;
    logic drop;
    logic age_rd;
    logic age_chk;
    logic resp;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hit;
    logic srch_end;
    logic fl_empty;
    logic age_left;
    logic out_free;
    logic [1:0] kind;
  } stat_t;

endpackage

FILE: rtl/ftwa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ftwa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ftwa_ctrl.sv
// Controller: sequences clear, search, create, delete and age scan.
`timescale 1ns / 1ps
module ftwa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [1:0]     kind_i,
  input  ftwa_pkg::stat_t stat_i,
  output logic           in_ready_o,
  output ftwa_pkg::cmd_t  cmd_o
);
  import ftwa_pkg::*;

  state_e state_q, state_d;
  kind_e  req_kind;
  kind_e  in_kind;

  assign req_kind = kind_e'(stat_i.kind);
  assign in_kind  = kind_e'(kind_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = (in_kind == KIND_AGE) ? S_AREAD : S_SRCH;
      end
      S_SRCH: begin
        if (stat_i.hit) begin
          state_d = (req_kind == KIND_DEL) ? S_DROP : S_DONE;
        end else if (stat_i.srch_end) begin
          if (req_kind == KIND_GET && !stat_i.fl_empty) state_d = S_FLRD;
          else state_d = S_DONE;
        end
      end
      S_FLRD:   state_d = S_CREATE;
      S_CREATE: state_d = S_DONE;
      S_DROP:   state_d = S_DONE;
      S_AREAD:  state_d = stat_i.age_left ? S_ACHK : S_DONE;
      S_ACHK:   state_d = S_AREAD;
      S_DONE: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: cmd_o.clr = 1'b1;
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_SRCH: begin
        cmd_o.srch = 1'b1;
        if (!stat_i.hit && stat_i.srch_end) begin
          if (req_kind == KIND_GET) cmd_o.full = stat_i.fl_empty;
          else cmd_o.miss = 1'b1;
        end
      end
      S_FLRD:   ;
      S_CREATE: cmd_o.create = 1'b1;
      S_DROP:   cmd_o.drop = 1'b1;
      S_AREAD:  cmd_o.age_rd = stat_i.age_left;
      S_ACHK:   cmd_o.age_chk = 1'b1;
      S_DONE:   cmd_o.resp = stat_i.out_free;
      default:  ;
    endcase
  end

endmodule

FILE: rtl/ftwa_dp.sv
// Datapath: entry and free-index memories, counters, compares and result registers.
`timescale 1ns / 1ps
module ftwa_dp #(
  parameter int unsigned ENTRIES = ftwa_pkg::EntriesDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ftwa_pkg::cmd_t                   cmd_i,
  output ftwa_pkg::stat_t                  stat_o,
  input  logic                             cfg_we_i,
  input  logic [ftwa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ftwa_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [1:0]                       kind_i,
  input  logic [ftwa_pkg::KEY_W-1:0]       key_low_i,
  input  logic [ftwa_pkg::KEY_W-1:0]       key_high_i,
  input  logic [ftwa_pkg::TIME_W-1:0]      now_i,
  input  logic                             timeout_flag_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [1:0]                       status_o,
  output logic [ftwa_pkg::SLOT_W-1:0]      slot_o,
  output logic                             created_o,
  output logic [ftwa_pkg::TIME_W-1:0]      created_time_o,
  output logic [ftwa_pkg::CNT_W-1:0]       expired_count_o,
  output logic [ftwa_pkg::CNT_W-1:0]       active_flows_o
);
  import ftwa_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CW    = IDX_W + 1;
  localparam int unsigned EW    = $bits(entry_t);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [CW-1:0]    FULL_CNT = CW'(ENTRIES);

  logic [TIME_W-1:0]   timeout_q;
  logic [BUDGET_W-1:0] budget_q;

  logic [1:0]        kind_q;
  logic [KEY_W-1:0]  key_lo_q, key_hi_q;
  logic [TIME_W-1:0] now_q;

  logic [IDX_W-1:0]  clr_cnt_q;
  logic [CW-1:0]     srch_cnt_q;
  logic              pend_q;
  logic [IDX_W-1:0]  pend_addr_q;
  logic [CW-1:0]     free_q;
  logic [CW-1:0]     active_q;
  logic [IDX_W-1:0]  cursor_q;
  logic [IDX_W-1:0]  age_addr_q;
  logic [BUDGET_W-1:0] visits_q;

  logic [1:0]        res_status_q;
  logic [IDX_W-1:0]  res_slot_q;
  logic              res_created_q;
  logic [TIME_W-1:0] res_ctime_q;
  logic [CNT_W-1:0]  res_exp_q;

  logic              out_valid_q;
  logic [1:0]        out_status_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic              out_created_q;
  logic [TIME_W-1:0] out_ctime_q;
  logic [CNT_W-1:0]  out_exp_q;
  logic [CNT_W-1:0]  out_active_q;

  logic [EW-1:0]     e_rdata, e_wdata;
  entry_t            e_rd, e_wr;
  logic              e_we;
  logic [IDX_W-1:0]  e_waddr, e_raddr;
  logic [IDX_W-1:0]  fl_rdata, fl_wdata, fl_waddr, fl_raddr;
  logic              fl_we;

  logic              hit, expire, rel, push;
  logic [IDX_W-1:0]  rel_slot;
  logic [TIME_W-1:0] idle_time;

  assign e_rd      = entry_t'(e_rdata);
  assign hit       = pend_q && e_rd.valid && (e_rd.key_lo == key_lo_q) &&
                     (e_rd.key_hi == key_hi_q);
  assign idle_time = now_q - e_rd.touched;
  assign expire    = e_rd.valid && (idle_time > timeout_q);
  assign rel       = cmd_i.drop || (cmd_i.age_chk && expire);
  assign rel_slot  = cmd_i.drop ? res_slot_q : age_addr_q;
  assign push      = rel && (free_q < FULL_CNT);

  always_comb begin
    e_wr           = '0;
    e_waddr        = rel_slot;
    e_we           = rel;
    if (cmd_i.clr) begin
      e_we    = 1'b1;
      e_waddr = clr_cnt_q;
    end else if (cmd_i.create) begin
      e_we         = 1'b1;
      e_waddr      = fl_rdata;
      e_wr.valid   = 1'b1;
      e_wr.key_hi  = key_hi_q;
      e_wr.key_lo  = key_lo_q;
      e_wr.birth   = now_q;
      e_wr.touched = now_q;
    end
  end

  assign e_wdata = EW'(e_wr);
  assign e_raddr = cmd_i.srch ? srch_cnt_q[IDX_W-1:0] : cursor_q;

  assign fl_raddr = IDX_W'(free_q - CW'(1));
  assign fl_we    = cmd_i.clr || push;
  assign fl_waddr = cmd_i.clr ? clr_cnt_q : free_q[IDX_W-1:0];
  assign fl_wdata = cmd_i.clr ? (LAST_IDX - clr_cnt_q) : rel_slot;

  ftwa_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  ftwa_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (fl_we),
    .waddr_i (fl_waddr),
    .wdata_i (fl_wdata),
    .raddr_i (fl_raddr),
    .rdata_o (fl_rdata)
  );

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= '0;
      budget_q  <= BUDGET_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_IDLE_TIMEOUT: timeout_q <= cfg_data_i;
        CFG_SCAN_BUDGET:  budget_q  <= cfg_data_i[BUDGET_W-1:0];
        default: ;
      endcase
    end
  end

  // request beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= kind_i;
      key_lo_q <= key_low_i;
      key_hi_q <= key_high_i;
      now_q    <= now_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      srch_cnt_q  <= '0;
      pend_q      <= 1'b0;
      pend_addr_q <= '0;
      free_q      <= FULL_CNT;
      active_q    <= '0;
      cursor_q    <= '0;
      age_addr_q  <= '0;
      visits_q    <= '0;
    end else begin
      if (cmd_i.clr) clr_cnt_q <= clr_cnt_q + IDX_W'(1);
      if (cmd_i.load) begin
        srch_cnt_q <= '0;
        pend_q     <= 1'b0;
        visits_q   <= budget_q;
      end else if (cmd_i.srch) begin
        pend_q      <= !hit && (srch_cnt_q < FULL_CNT);
        pend_addr_q <= srch_cnt_q[IDX_W-1:0];
        if (srch_cnt_q < FULL_CNT) srch_cnt_q <= srch_cnt_q + CW'(1);
      end
      if (cmd_i.age_rd) begin
        age_addr_q <= cursor_q;
        cursor_q   <= (cursor_q == LAST_IDX) ? '0 : cursor_q + IDX_W'(1);
        visits_q   <= visits_q - BUDGET_W'(1);
      end
      if (cmd_i.create) begin
        free_q   <= free_q - CW'(1);
        active_q <= active_q + CW'(1);
      end else if (rel) begin
        if (push) free_q <= free_q + CW'(1);
        if (active_q != '0) active_q <= active_q - CW'(1);
      end
    end
  end

  // result of the request at work
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_status_q  <= ST_OK;
      res_slot_q    <= '0;
      res_created_q <= 1'b0;
      res_ctime_q   <= '0;
      res_exp_q     <= '0;
    end else begin
      if (cmd_i.srch && hit) begin
        res_slot_q  <= pend_addr_q;
        res_ctime_q <= e_rd.birth;
      end
      if (cmd_i.miss) res_status_q <= ST_MISS;
      if (cmd_i.full) res_status_q <= ST_FULL;
      if (cmd_i.create) begin
        res_slot_q    <= fl_rdata;
        res_created_q <= 1'b1;
        res_ctime_q   <= now_q;
      end
      if (cmd_i.age_chk && expire) res_exp_q <= res_exp_q + CNT_W'(1);
    end
  end

  // output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.resp) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp) begin
      out_status_q  <= res_status_q;
      out_slot_q    <= SLOT_W'(res_slot_q);
      out_created_q <= res_created_q;
      out_ctime_q   <= res_ctime_q;
      out_exp_q     <= res_exp_q;
      out_active_q  <= CNT_W'(active_q);
    end
  end

  assign stat_o.clr_last = (clr_cnt_q == LAST_IDX);
  assign stat_o.hit      = hit;
  assign stat_o.srch_end = !pend_q && (srch_cnt_q == FULL_CNT);
  assign stat_o.fl_empty = (free_q == '0);
  assign stat_o.age_left = (visits_q != '0);
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign stat_o.kind     = kind_q;

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign slot_o          = out_slot_q;
  assign created_o       = out_created_q;
  assign created_time_o  = out_ctime_q;
  assign expired_count_o = out_exp_q;
  assign active_flows_o  = out_active_q;

endmodule

FILE: rtl/flow_table_with_aging_core.sv
// Top level: exact-match flow table with idle aging.
//
//   channel | direction | handshake               | payload
//   in      | in        | in_valid_i / in_ready_o | kind, key_low, key_high, now, timeout_flag
//   out     | out       | out_valid_o/out_ready_i | status, slot, created, created_time,
//           |           |                         | expired_count, active_flows
//   cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Lookup, get-or-create and delete walk the entry memory one slot per cycle
// through the single read port of the entry RAM. Create then reads the free-index
// stack and writes the new entry; delete clears the slot. An age scan reads, then
// checks each visited slot. After reset a clearing pass fills the free-index stack
// and clears entry valid bits; no input beat is taken meanwhile (cfg always is).
// A finished beat waits in the output register; the next one is taken meanwhile.
`timescale 1ns / 1ps
module flow_table_with_aging_core #(
  parameter int unsigned ENTRIES = ftwa_pkg::EntriesDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       kind_i,
  input  logic [ftwa_pkg::KEY_W-1:0]       key_low_i,
  input  logic [ftwa_pkg::KEY_W-1:0]       key_high_i,
  input  logic [ftwa_pkg::TIME_W-1:0]      now_i,
  input  logic                             timeout_flag_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       status_o,
  output logic [ftwa_pkg::SLOT_W-1:0]      slot_o,
  output logic                             created_o,
  output logic [ftwa_pkg::TIME_W-1:0]      created_time_o,
  output logic [ftwa_pkg::CNT_W-1:0]       expired_count_o,
  output logic [ftwa_pkg::CNT_W-1:0]       active_flows_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ftwa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ftwa_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import ftwa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  ftwa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  ftwa_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .kind_i          (kind_i),
    .key_low_i       (key_low_i),
    .key_high_i      (key_high_i),
    .now_i           (now_i),
    .timeout_flag_i  (timeout_flag_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .slot_o          (slot_o),
    .created_o       (created_o),
    .created_time_o  (created_time_o),
    .expired_count_o (expired_count_o),
    .active_flows_o  (active_flows_o)
  );

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_MISS || status_o == ST_FULL))
    else $error("undefined status code");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> slot_o == '0 && created_time_o == '0 && !created_o)
    else $error("failed request carries slot data");

  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second beat taken while one is at work");
`endif

endmodule
